### design/tkn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the flat JSON object tokenizer.
// No dependencies; every module of the block imports this package.
package tkn_pkg;

   // Most result words that one input word can cause.
   localparam int MAX_RESULTS = 3;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [3:0] {
      PH_OPEN         = 4'd0,
      PH_KEY_OR_CLOSE = 4'd1,
      PH_KEY_STR      = 4'd2,
      PH_KEY_ESC      = 4'd3,
      PH_KEY_HEX      = 4'd4,
      PH_COLON        = 4'd5,
      PH_VAL_START    = 4'd6,
      PH_VAL_STR      = 4'd7,
      PH_VAL_ESC      = 4'd8,
      PH_VAL_HEX      = 4'd9,
      PH_LITERAL      = 4'd10,
      PH_RAW          = 4'd11,
      PH_AFTER_VALUE  = 4'd12,
      PH_DONE         = 4'd13,
      PH_ERROR        = 4'd14
   } phase_type;

   typedef enum logic [2:0] {
      KIND_KEY_BYTE = 3'd0,
      KIND_VAL_BYTE = 3'd1,
      KIND_KEY_END  = 3'd2,
      KIND_VAL_END  = 3'd3,
      KIND_DONE     = 3'd4,
      KIND_ERROR    = 3'd5
   } kind_type;

   // All results caused by one input word, in order.
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  data;
      kind_type [MAX_RESULTS-1:0]   kind;
   } bundle_type;

endpackage

### design/json_flat_object_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the streaming tokenizer for one flat JSON object.
// Depends on tkn_pkg, tkn_front, tkn_queue and tkn_back.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_mode, req_in_byte
//   rsp_      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_out_kind, rsp_last
//
// The front takes one input word per cycle while the bundle queue has room;
// the queue is QUEUE_DEPTH bundles deep and req_stall is high only while it is full.
// The back sends one result word per cycle while rsp_stall is low; an input word
// that causes n results (n is zero to three) gives n result words, and words with no
// result use only the front. Results pass through the queue and the output register.
// Reset is synchronous and active high; it returns the parser to expecting an opening
// brace and empties the queue and the output register.
module json_flat_object_tokenizer import tkn_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_out_kind,
   output logic       rsp_last
);

   // Bundle traffic between the three parts.
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_empty;
   bundle_type push_bundle;
   bundle_type head;

   // The front holds the whole parser state and classifies each byte in the
   // cycle it is accepted; every result that byte causes goes into one bundle.
   tkn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // The queue lets the front keep taking bytes while the back is held up by
   // a stalled result port or is still spelling out a multi-result bundle.
   tkn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (pop),
      .empty       (queue_empty),
      .head        (head)
   );

   // The back walks through the head bundle one result per cycle while rsp_stall is
   // low, and marks the final result of each input word with rsp_last.
   tkn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_last     (rsp_last)
   );

endmodule

### design/tkn_front.sv
`timescale 1ns / 1ps
// Front part of the tokenizer: accepts input words, runs the parser state and
// gathers the results of each word into one bundle. Depends on tkn_pkg.
module tkn_front import tkn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   input  logic       queue_full,
   output logic       push,
   output bundle_type push_bundle
);

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_VT        = 8'h0B;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;

   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [7:0]  UTF_LEAD2      = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3      = 8'hE0;
   localparam logic [7:0]  UTF_CONT       = 8'h80;
   localparam logic [5:0]  UTF_MASK       = 6'h3F;

   phase_type   phase_ff, phase_in;
   logic [11:0] esc_ff, esc_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [2:0]  lit_idx_ff, lit_idx_in;
   logic        lit_false_ff, lit_false_in;
   logic        slash_ff, slash_in;
   logic        comment_ff, comment_in;

   logic        accept;
   logic        skip_phase;
   logic        key_phase;
   kind_type    byte_kind;
   logic        ws;
   logic        raw_ws;
   logic        act_en;
   logic        raw_en;
   logic        hex_ok;
   logic [3:0]  hex_v;
   logic [15:0] code;
   logic [2:0]  lit_len;
   logic [2:0]  lit_next;
   bundle_type  bun;

   function automatic bundle_type put_res(input bundle_type b, input logic [7:0] d,
                                          input kind_type k);
      bundle_type r;
      r = b;
      if (r.count < 2'(MAX_RESULTS)) begin
         r.data[r.count] = d;
         r.kind[r.count] = k;
         r.count = r.count + 2'd1;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
   endfunction

   function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (is_false) begin
         unique case (idx)
            3'd0: r = "f";
            3'd1: r = "a";
            3'd2: r = "l";
            3'd3: r = "s";
            3'd4: r = "e";
            default: r = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0: r = "t";
            3'd1: r = "r";
            3'd2: r = "u";
            3'd3: r = "e";
            default: r = 8'h00;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] esc_char(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         "b":     r = 8'h08;
         "f":     r = 8'h0C;
         "n":     r = 8'h0A;
         "r":     r = 8'h0D;
         "t":     r = 8'h09;
         default: r = c;
      endcase
      return r;
   endfunction

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;

   assign skip_phase = phase_ff == PH_OPEN || phase_ff == PH_KEY_OR_CLOSE ||
                       phase_ff == PH_COLON || phase_ff == PH_VAL_START ||
                       phase_ff == PH_AFTER_VALUE;
   assign key_phase  = phase_ff == PH_KEY_STR || phase_ff == PH_KEY_ESC ||
                       phase_ff == PH_KEY_HEX;
   assign byte_kind  = key_phase ? KIND_KEY_BYTE : KIND_VAL_BYTE;
   assign ws         = is_space(req_in_byte);
   assign raw_ws     = ws || req_in_byte == CH_COMMA || req_in_byte == CH_RBRACE;
   assign lit_len    = lit_false_ff ? 3'd5 : 3'd4;
   assign lit_next   = lit_idx_ff + 3'd1;
   assign code       = {esc_ff, hex_v};

   always_comb begin
      hex_ok = 1'b1;
      hex_v  = 4'h0;
      if (req_in_byte >= "0" && req_in_byte <= "9") begin
         hex_v = 4'(req_in_byte - "0");
      end else if (req_in_byte >= "a" && req_in_byte <= "f") begin
         hex_v = 4'(req_in_byte - "a" + 8'd10);
      end else if (req_in_byte >= "A" && req_in_byte <= "F") begin
         hex_v = 4'(req_in_byte - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      esc_in       = esc_ff;
      hex_cnt_in   = hex_cnt_ff;
      lit_idx_in   = lit_idx_ff;
      lit_false_in = lit_false_ff;
      slash_in     = slash_ff;
      comment_in   = comment_ff;
      bun          = '0;
      act_en       = 1'b0;
      raw_en       = 1'b0;
      if (accept) begin
         if (req_mode) begin
            if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
               bun = put_res(bun, 8'h00, KIND_ERROR);
            end
            phase_in     = PH_OPEN;
            esc_in       = '0;
            hex_cnt_in   = '0;
            lit_idx_in   = '0;
            lit_false_in = 1'b0;
            slash_in     = 1'b0;
            comment_in   = 1'b0;
         end else if (skip_phase) begin
            if (comment_ff) begin
               if (req_in_byte == CH_LF) begin
                  comment_in = 1'b0;
               end
            end else if (slash_ff) begin
               slash_in = 1'b0;
               if (req_in_byte == CH_SLASH) begin
                  comment_in = 1'b1;
               end else if (phase_ff == PH_VAL_START) begin
                  bun      = put_res(bun, CH_SLASH, KIND_VAL_BYTE);
                  phase_in = PH_RAW;
                  raw_en   = 1'b1;
               end else begin
                  bun      = put_res(bun, 8'h00, KIND_ERROR);
                  phase_in = PH_ERROR;
               end
            end else if (ws) begin
               phase_in = phase_ff;
            end else if (req_in_byte == CH_SLASH) begin
               slash_in = 1'b1;
            end else begin
               act_en = 1'b1;
            end
         end else begin
            act_en = 1'b1;
         end

         if (act_en) begin
            unique case (phase_ff)
               PH_OPEN: begin
                  if (req_in_byte == CH_LBRACE) begin
                     phase_in = PH_KEY_OR_CLOSE;
                  end else begin
                     bun      = put_res(bun, 8'h00, KIND_ERROR);
                     phase_in = PH_ERROR;
                  end
               end
               PH_KEY_OR_CLOSE, PH_AFTER_VALUE: begin
                  priority if (phase_ff == PH_AFTER_VALUE && req_in_byte == CH_COMMA) begin
                     phase_in = PH_KEY_OR_CLOSE;
                  end else if (req_in_byte == CH_RBRACE) begin
                     bun      = put_res(bun, 8'h00, KIND_DONE);
                     phase_in = PH_DONE;
                  end else if (req_in_byte == CH_QUOTE) begin
                     phase_in = PH_KEY_STR;
                  end else begin
                     bun      = put_res(bun, 8'h00, KIND_ERROR);
                     phase_in = PH_ERROR;
                  end
               end
               PH_KEY_STR, PH_VAL_STR: begin
                  if (req_in_byte == CH_QUOTE) begin
                     bun      = put_res(bun, 8'h00, key_phase ? KIND_KEY_END : KIND_VAL_END);
                     phase_in = key_phase ? PH_COLON : PH_AFTER_VALUE;
                  end else if (req_in_byte == CH_BACKSLASH) begin
                     phase_in = key_phase ? PH_KEY_ESC : PH_VAL_ESC;
                  end else begin
                     bun = put_res(bun, req_in_byte, byte_kind);
                  end
               end
               PH_KEY_ESC, PH_VAL_ESC: begin
                  if (req_in_byte == "u") begin
                     esc_in     = '0;
                     hex_cnt_in = '0;
                     phase_in   = key_phase ? PH_KEY_HEX : PH_VAL_HEX;
                  end else begin
                     bun      = put_res(bun, esc_char(req_in_byte), byte_kind);
                     phase_in = key_phase ? PH_KEY_STR : PH_VAL_STR;
                  end
               end
               PH_KEY_HEX, PH_VAL_HEX: begin
                  if (!hex_ok) begin
                     bun      = put_res(bun, 8'h00, KIND_ERROR);
                     phase_in = PH_ERROR;
                  end else if (hex_cnt_ff == 2'd3) begin
                     if (code < ONE_BYTE_LIMIT) begin
                        bun = put_res(bun, code[7:0], byte_kind);
                     end else if (code < TWO_BYTE_LIMIT) begin
                        bun = put_res(bun, UTF_LEAD2 | {3'b000, code[10:6]}, byte_kind);
                        bun = put_res(bun, UTF_CONT | {2'b00, code[5:0] & UTF_MASK},
                                      byte_kind);
                     end else begin
                        bun = put_res(bun, UTF_LEAD3 | {4'h0, code[15:12]}, byte_kind);
                        bun = put_res(bun, UTF_CONT | {2'b00, code[11:6] & UTF_MASK},
                                      byte_kind);
                        bun = put_res(bun, UTF_CONT | {2'b00, code[5:0] & UTF_MASK},
                                      byte_kind);
                     end
                     esc_in     = '0;
                     hex_cnt_in = '0;
                     phase_in   = key_phase ? PH_KEY_STR : PH_VAL_STR;
                  end else begin
                     esc_in     = {esc_ff[7:0], hex_v};
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end
               end
               PH_COLON: begin
                  if (req_in_byte == CH_COLON) begin
                     phase_in = PH_VAL_START;
                  end else begin
                     bun      = put_res(bun, 8'h00, KIND_ERROR);
                     phase_in = PH_ERROR;
                  end
               end
               PH_VAL_START: begin
                  if (req_in_byte == CH_QUOTE) begin
                     phase_in = PH_VAL_STR;
                  end else if (req_in_byte == "t" || req_in_byte == "f") begin
                     bun          = put_res(bun, req_in_byte, KIND_VAL_BYTE);
                     lit_false_in = req_in_byte == "f";
                     lit_idx_in   = 3'd1;
                     phase_in     = PH_LITERAL;
                  end else begin
                     phase_in = PH_RAW;
                     raw_en   = 1'b1;
                  end
               end
               PH_RAW: begin
                  raw_en = 1'b1;
               end
               PH_LITERAL: begin
                  if (lit_idx_ff < lit_len &&
                      req_in_byte == lit_char(lit_false_ff, lit_idx_ff)) begin
                     bun = put_res(bun, req_in_byte, KIND_VAL_BYTE);
                     if (lit_next >= lit_len) begin
                        bun        = put_res(bun, 8'h00, KIND_VAL_END);
                        lit_idx_in = '0;
                        phase_in   = PH_AFTER_VALUE;
                     end else begin
                        lit_idx_in = lit_next;
                     end
                  end else begin
                     bun      = put_res(bun, 8'h00, KIND_ERROR);
                     phase_in = PH_ERROR;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end

         // A raw primitive runs to a comma, a closing brace or whitespace.
         if (raw_en) begin
            if (raw_ws) begin
               bun = put_res(bun, 8'h00, KIND_VAL_END);
               if (req_in_byte == CH_COMMA) begin
                  phase_in = PH_KEY_OR_CLOSE;
               end else if (req_in_byte == CH_RBRACE) begin
                  bun      = put_res(bun, 8'h00, KIND_DONE);
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_AFTER_VALUE;
               end
            end else begin
               bun = put_res(bun, req_in_byte, KIND_VAL_BYTE);
            end
         end
      end
   end

   assign push        = accept && bun.count != 2'd0;
   assign push_bundle = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         esc_ff       <= '0;
         hex_cnt_ff   <= '0;
         lit_idx_ff   <= '0;
         lit_false_ff <= 1'b0;
         slash_ff     <= 1'b0;
         comment_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         hex_cnt_ff   <= hex_cnt_in;
         lit_idx_ff   <= lit_idx_in;
         lit_false_ff <= lit_false_in;
         slash_ff     <= slash_in;
         comment_ff   <= comment_in;
      end
   end

   // A slash or a comment is only ever pending while whitespace is skipped.
   assert property (@(posedge clock) disable iff (reset)
      (slash_ff || comment_ff) |-> skip_phase)
      else $error("slash or comment pending outside a skip phase");

endmodule

### design/tkn_queue.sv
`timescale 1ns / 1ps
// Short queue of result bundles between the front and the back.
// Depends on tkn_pkg for the bundle type.
module tkn_queue import tkn_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output bundle_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type        mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from an empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

### design/tkn_back.sv
`timescale 1ns / 1ps
// Back part of the tokenizer: takes bundles from the queue and sends their
// results one word per unstalled cycle via an output register. Depends on tkn_pkg.
module tkn_back import tkn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  bundle_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_out_kind,
   output logic       rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] data_ff, data_in;
   kind_type   kind_ff, kind_in;
   logic       last_ff, last_in;
   logic       load;
   logic       take;
   logic       final_res;

   assign load      = !valid_ff || !rsp_stall;
   assign take      = load && !queue_empty;
   assign final_res = idx_ff == head.count - 2'd1;
   assign pop       = take && final_res;

   always_comb begin
      valid_in = load ? !queue_empty : valid_ff;
      idx_in   = idx_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (take) begin
         idx_in  = final_res ? 2'd0 : idx_ff + 2'd1;
         data_in = head.data[idx_ff];
         kind_in = head.kind[idx_ff];
         last_in = final_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = data_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_last     = last_ff;

   // The position within the head bundle never runs past its result count.
   assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> idx_ff < head.count)
      else $error("result index beyond bundle count");

endmodule

### verif/json_flat_object_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking regression for json_flat_object_tokenizer: directed texts, then random objects.
// Depends on tkn_pkg and the json_flat_object_tokenizer RTL only; reads and writes no files.
module json_flat_object_tokenizer_tb import tkn_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;
   // Words to send in the random part, ignored trailing bytes not included.
   localparam int RANDOM_WORDS = 230;

   // Keyword texts and character sets, highest byte first as string constants are laid out.
   localparam logic [31:0]  TRUE_TEXT  = "true";
   localparam logic [39:0]  FALSE_TEXT = "false";
   localparam logic [47:0]  BLANKS     = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   localparam logic [71:0]  ESC_CHARS  = "bfnrt\"\\/q";
   localparam logic [151:0] RAW_CHARS  = "0123456789-+.eE\"/xn";

   // One result word as the block should present it.
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } token_word_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_mode    = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_out_kind;
   logic       rsp_last;

   // Results still owed by the block, oldest first, and those of the word being predicted.
   token_word_type expected_tokens[$];
   token_word_type step_tokens[$];
   // Text of the object currently being played.
   logic [7:0]  script[$];

   // When set, neither side idles: the sender keeps valid up and the receiver never stalls.
   bit          steady       = 1'b0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned words_sent   = 0;

   // Private copy of the parser state, kept in step with every accepted word.
   phase_type   phase;
   logic [15:0] code_acc;
   logic [2:0]  digit_count;
   logic [2:0]  lit_pos;
   logic        lit_false;
   logic        slash_wait;
   logic        comment_on;

   always #10 clock = ~clock;

   json_flat_object_tokenizer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_last     (rsp_last)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor of the tokenizer, one accepted word at a time.
   // ---------------------------------------------------------------------------------------

   function automatic void clear_parser();
      phase       = PH_OPEN;
      code_acc    = '0;
      digit_count = '0;
      lit_pos     = '0;
      lit_false   = 1'b0;
      slash_wait  = 1'b0;
      comment_on  = 1'b0;
   endfunction

   // The block gives at most MAX_RESULTS words per input word; anything beyond is dropped.
   function automatic void emit(input logic [7:0] b, input kind_type k);
      token_word_type t;
      if (step_tokens.size() < MAX_RESULTS) begin
         t.data = b;
         t.kind = k;
         t.last = 1'b0;
         step_tokens.insert(step_tokens.size(), t);
      end
   endfunction

   function automatic void parse_error();
      emit(8'h00, KIND_ERROR);
      phase = PH_ERROR;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
   endfunction

   // Phases in which whitespace and comments between tokens are skipped.
   function automatic bit skips_blanks(input phase_type p);
      return p == PH_OPEN || p == PH_KEY_OR_CLOSE || p == PH_COLON ||
             p == PH_VAL_START || p == PH_AFTER_VALUE;
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // A bare primitive runs until a comma, a closing brace or whitespace.
   function automatic void raw_char(input logic [7:0] c);
      if (c == "," || c == "}" || is_blank(c)) begin
         emit(8'h00, KIND_VAL_END);
         if (c == ",") begin
            phase = PH_KEY_OR_CLOSE;
         end else if (c == "}") begin
            emit(8'h00, KIND_DONE);
            phase = PH_DONE;
         end else begin
            phase = PH_AFTER_VALUE;
         end
      end else begin
         emit(c, KIND_VAL_BYTE);
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      bit          is_key;
      kind_type    kind;
      phase_type   str_phase;
      int          nib;
      logic [2:0]  lit_len;
      logic [7:0]  lit_char;
      is_key = phase == PH_KEY_STR || phase == PH_KEY_ESC || phase == PH_KEY_HEX;
      if (is_key) begin
         kind      = KIND_KEY_BYTE;
         str_phase = PH_KEY_STR;
      end else begin
         kind      = KIND_VAL_BYTE;
         str_phase = PH_VAL_STR;
      end
      case (phase)
         PH_OPEN: begin
            if (c == "{") phase = PH_KEY_OR_CLOSE;
            else parse_error();
         end
         PH_AFTER_VALUE, PH_KEY_OR_CLOSE: begin
            if (phase == PH_AFTER_VALUE && c == ",") begin
               phase = PH_KEY_OR_CLOSE;
            end else if (c == "}") begin
               emit(8'h00, KIND_DONE);
               phase = PH_DONE;
            end else if (c == "\"") begin
               phase = PH_KEY_STR;
            end else begin
               parse_error();
            end
         end
         PH_KEY_STR, PH_VAL_STR: begin
            if (c == "\"") begin
               if (is_key) begin
                  emit(8'h00, KIND_KEY_END);
                  phase = PH_COLON;
               end else begin
                  emit(8'h00, KIND_VAL_END);
                  phase = PH_AFTER_VALUE;
               end
            end else if (c == "\\") begin
               if (is_key) phase = PH_KEY_ESC;
               else phase = PH_VAL_ESC;
            end else begin
               emit(c, kind);
            end
         end
         PH_KEY_ESC, PH_VAL_ESC: begin
            if (c == "u") begin
               code_acc    = '0;
               digit_count = '0;
               if (is_key) phase = PH_KEY_HEX;
               else phase = PH_VAL_HEX;
            end else begin
               // Unknown escapes pass the escaped byte through unchanged.
               case (c)
                  "b":     emit(8'h08, kind);
                  "f":     emit(8'h0C, kind);
                  "n":     emit(8'h0A, kind);
                  "r":     emit(8'h0D, kind);
                  "t":     emit(8'h09, kind);
                  default: emit(c, kind);
               endcase
               phase = str_phase;
            end
         end
         PH_KEY_HEX, PH_VAL_HEX: begin
            nib = hex_nibble(c);
            if (nib < 0) begin
               parse_error();
            end else begin
               code_acc    = {code_acc[11:0], nib[3:0]};
               digit_count = digit_count + 3'd1;
               if (digit_count >= 3'd4) begin
                  // UTF-8 encoding of the gathered code, one to three bytes.
                  if (code_acc < 16'h0080) begin
                     emit(code_acc[7:0], kind);
                  end else if (code_acc < 16'h0800) begin
                     emit({3'b110, code_acc[10:6]}, kind);
                     emit({2'b10, code_acc[5:0]}, kind);
                  end else begin
                     emit({4'hE, code_acc[15:12]}, kind);
                     emit({2'b10, code_acc[11:6]}, kind);
                     emit({2'b10, code_acc[5:0]}, kind);
                  end
                  digit_count = '0;
                  code_acc    = '0;
                  phase       = str_phase;
               end
            end
         end
         PH_COLON: begin
            if (c == ":") phase = PH_VAL_START;
            else parse_error();
         end
         PH_VAL_START: begin
            if (c == "\"") begin
               phase = PH_VAL_STR;
            end else if (c == "t" || c == "f") begin
               emit(c, KIND_VAL_BYTE);
               lit_false = c == "f";
               lit_pos   = 3'd1;
               phase     = PH_LITERAL;
            end else begin
               phase = PH_RAW;
               raw_char(c);
            end
         end
         PH_RAW: raw_char(c);
         PH_LITERAL: begin
            if (lit_false) begin
               lit_len  = 3'd5;
               lit_char = FALSE_TEXT[8*(4-int'(lit_pos)) +: 8];
            end else begin
               lit_len  = 3'd4;
               lit_char = TRUE_TEXT[8*(3-int'(lit_pos)) +: 8];
            end
            if (lit_pos < lit_len && c == lit_char) begin
               emit(c, KIND_VAL_BYTE);
               lit_pos = lit_pos + 3'd1;
               if (lit_pos >= lit_len) begin
                  emit(8'h00, KIND_VAL_END);
                  lit_pos = '0;
                  phase   = PH_AFTER_VALUE;
               end
            end else begin
               parse_error();
            end
         end
         default: ;
      endcase
   endfunction

   // Comment and slash handling in front of the token parser.
   function automatic void tokenize_byte(input logic [7:0] c);
      if (!skips_blanks(phase)) begin
         parse_char(c);
      end else if (comment_on) begin
         if (c == 8'h0A) comment_on = 1'b0;
      end else if (slash_wait) begin
         slash_wait = 1'b0;
         if (c == "/") begin
            comment_on = 1'b1;
         end else begin
            // A lone slash is a token byte; only a bare value carries on with this byte.
            parse_char("/");
            if (phase == PH_RAW) parse_char(c);
         end
      end else if (!is_blank(c)) begin
         if (c == "/") slash_wait = 1'b1;
         else parse_char(c);
      end
   endfunction

   function automatic void predict_word(input logic mode, input logic [7:0] c);
      token_word_type t;
      step_tokens.delete();
      if (mode) begin
         if (phase != PH_DONE && phase != PH_ERROR) emit(8'h00, KIND_ERROR);
         clear_parser();
      end else begin
         tokenize_byte(c);
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.insert(step_tokens.size(), t);
      end
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random stalls and the comparison of every accepted result word.
   // ---------------------------------------------------------------------------------------

   // The receiver stalls at random with a chance of about 36 in a hundred, except in the steady stretch.
   always @(posedge clock) rsp_stall <= !steady && ($urandom_range(0, 99) < 36);

   // Outputs are sampled at the edge, before any register of the block has moved.
   always @(posedge clock) begin : check_tokens
      token_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, got byte %02h kind %0d last %0b",
                     $time, rsp_out_byte, rsp_out_kind, rsp_last);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_out_byte !== want.data || rsp_out_kind !== want.kind ||
                rsp_last !== want.last) begin
               $display("%0t: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                        $time, want.data, want.kind, want.last,
                        rsp_out_byte, rsp_out_kind, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("json_flat_object_tokenizer regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sending side. push_word leaves req_valid high after its word has been taken, so the
   // next word can follow at once; anything that waits must lower valid first.
   // ---------------------------------------------------------------------------------------

   task automatic push_word(input logic mode, input logic [7:0] b);
      int unsigned gap;
      // Before about 28 words in a hundred, valid goes low for a random gap, so the sender idles.
      if (!steady && $urandom_range(0, 99) < 28) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(mode, b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_word(1'b0, s.getc(i));
   endtask

   // Holds the sender back until every owed result has come out.
   task automatic wait_for_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random object text. Mostly well-formed objects with random content, so that every
   // phase of the parser is reached; some are corrupted, cut short or replaced by noise.
   // ---------------------------------------------------------------------------------------

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      if ($urandom_range(0, 1)) return "A" + n - 8'd10;
      return "a" + n - 8'd10;
   endfunction

   // Whitespace between tokens, now and then with a line comment.
   function automatic void add_blanks();
      logic [7:0] b;
      repeat ($urandom_range(0, 2))
         script.insert(script.size(), BLANKS[8*$urandom_range(0, 5) +: 8]);
      if ($urandom_range(0, 7) == 0) begin
         script.insert(script.size(), "/");
         script.insert(script.size(), "/");
         repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == 8'h0A) b = "x";
            script.insert(script.size(), b);
         end
         script.insert(script.size(), 8'h0A);
      end
   endfunction

   function automatic void add_string_body();
      int          sel;
      logic [15:0] code;
      logic [7:0]  b;
      repeat ($urandom_range(0, 4)) begin
         sel = $urandom_range(0, 9);
         if (sel <= 5) begin
            if (sel == 5) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(32, 126));
            if (b == "\"" || b == "\\") b = "_";
            script.insert(script.size(), b);
         end else if (sel <= 7) begin
            script.insert(script.size(), "\\");
            script.insert(script.size(), ESC_CHARS[8*$urandom_range(0, 8) +: 8]);
         end else begin
            // Spread the codes over the one, two and three byte encodings.
            case ($urandom_range(0, 2))
               0:       code = 16'($urandom_range(0, 16'h007F));
               1:       code = 16'($urandom_range(16'h0080, 16'h07FF));
               default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            script.insert(script.size(), "\\");
            script.insert(script.size(), "u");
            for (int k = 3; k >= 0; k--) script.insert(script.size(), hex_char(code[4*k +: 4]));
         end
      end
   endfunction

   function automatic void add_value();
      logic [7:0] b;
      int         n;
      case ($urandom_range(0, 5))
         0, 1: begin
            script.insert(script.size(), "\"");
            add_string_body();
            script.insert(script.size(), "\"");
         end
         2: begin
            if ($urandom_range(0, 1)) begin
               for (int k = 4; k >= 0; k--) script.insert(script.size(), FALSE_TEXT[8*k +: 8]);
            end else begin
               for (int k = 3; k >= 0; k--) script.insert(script.size(), TRUE_TEXT[8*k +: 8]);
            end
         end
         3, 4: begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
               else b = RAW_CHARS[8*$urandom_range(0, 18) +: 8];
               // A leading t or f would start a keyword instead.
               if (k == 0 && (b == "t" || b == "f")) b = "0";
               script.insert(script.size(), b);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void make_object();
      int pairs;
      script.delete();
      script.insert(script.size(), "{");
      add_blanks();
      pairs = $urandom_range(0, 4);
      for (int i = 0; i < pairs; i++) begin
         script.insert(script.size(), "\"");
         add_string_body();
         script.insert(script.size(), "\"");
         add_blanks();
         script.insert(script.size(), ":");
         add_blanks();
         add_value();
         // Commas are usually present, sometimes missing and sometimes trailing.
         if (i < pairs - 1 || $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 5) != 0) begin
               add_blanks();
               script.insert(script.size(), ",");
            end else begin
               script.insert(script.size(), " ");
            end
         end
         add_blanks();
      end
      script.insert(script.size(), "}");
   endfunction

   task automatic play_object();
      int cut;
      make_object();
      case ($urandom_range(0, 9))
         0, 1: script[$urandom_range(0, script.size() - 1)] = 8'($urandom_range(0, 255));
         2: begin
            cut = $urandom_range(1, script.size() - 1);
            while (script.size() > cut) void'(script.pop_back());
         end
         3: begin
            script.delete();
            repeat ($urandom_range(1, 6))
               script.insert(script.size(), 8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      foreach (script[i]) push_word(1'b0, script[i]);
      words_sent += script.size() + 1;
      // Bytes after the end of an object are normally ignored and are not counted.
      repeat ($urandom_range(0, 2)) push_word(1'b0, 8'($urandom_range(0, 255)));
      push_word(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Key bytes at both extremes, two and three byte \u codes, the largest code, an unknown
   // escape, then a bad hex digit in a value; end of text after the error is silent.
   task automatic test_escapes();
      push_text("{\"");
      push_word(1'b0, 8'h00);
      push_word(1'b0, 8'hFF);
      push_text("\\u07FF\\uFFFF\\q\":\"\\u1g");
      push_word(1'b1, 8'h00);
   endtask

   // Vertical tab, carriage return, form feed and a line comment before the key, a true
   // followed straight away by the next key, then a false that goes wrong on its last letter.
   task automatic test_literals();
      push_text("\013{\015\014//c\n\"k\":true\"j\":falsy");
      push_word(1'b1, 8'hFF);
   endtask

   // A lone slash opening a bare value, an empty value, a bare value holding a quote and
   // a slash ended by a space, then two commas in a row.
   task automatic test_primitives();
      push_text("{\"a\":/q,\"b\":,\"c\":1\"/ ,,");
      push_word(1'b1, 8'h5A);
   endtask

   // Trailing comma and completion with text after it, a lone slash where a key belongs,
   // end of text inside an object, junk after a keyword, and a bare value closed by the brace.
   task automatic test_closing();
      push_text("{\"x\":false ,}z");
      push_word(1'b1, 8'h00);
      push_text("{/a");
      push_word(1'b1, 8'h00);
      push_text("{");
      push_word(1'b1, 8'hA5);
      push_text("{\"\":truex");
      push_word(1'b1, 8'h00);
      push_text("{\"n\":7}");
      push_word(1'b1, 8'h00);
   endtask

   // A stretch with no idling on either side, so the block runs at full rate.
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (3) play_object();
      wait_for_tokens();
      steady = 1'b0;
   endtask

   // The bulk of the run; halfway through the sender waits for the block to drain.
   task automatic test_random_objects();
      bit drained;
      drained    = 1'b0;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         play_object();
         if (!drained && words_sent > RANDOM_WORDS / 2) begin
            wait_for_tokens();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_escapes();
      test_literals();
      test_primitives();
      test_closing();
      test_back_to_back();
      test_random_objects();
      wait_for_tokens();
      // Leave room for anything stray.
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("json_flat_object_tokenizer regression: pass");
      end else begin
         $display("json_flat_object_tokenizer regression: fail");
      end
      $finish;
   end

endmodule
